[hdl/xtea_pkg.sv]
// ----------------------------------------------------------------------------
// XTEA package
// Constants and helper functions shared by the XTEA cipher pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned CycleCount = 32;
  localparam int unsigned NumStages  = 2 * CycleCount;
  localparam int unsigned WordW      = 32;
  localparam int unsigned NumKeys    = 4;
  localparam int unsigned KeySelW    = $clog2(NumKeys);
  localparam int unsigned AddrW      = 4;

  localparam logic [WordW-1:0] Delta = 32'h9e37_79b9;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [KeySelW-1:0] key_sel_t;

  // Register indexes of the key words on the APB port.
  typedef enum logic [KeySelW-1:0] {
    KEY_A = 2'd0,
    KEY_B = 2'd1,
    KEY_C = 2'd2,
    KEY_D = 2'd3
  } key_idx_e;

  // The non-linear mixing function of one half-round.
  function automatic word_t mix_word(word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // True where a half-round updates the first word (and takes its key from
  // the low sum bits); false where it updates the second word.
  function automatic logic stage_upd_first(int unsigned stage, logic dec);
    logic h;
    h = stage[0];
    return (h ^ dec) == 1'b0;
  endfunction

  // Round sum seen by a given half-round.
  function automatic word_t stage_sum(int unsigned stage, logic dec);
    int unsigned c;
    int unsigned k;
    c = stage / 2;
    if (!dec) begin
      k = (stage % 2 == 0) ? c : c + 1;
    end else begin
      k = (stage % 2 == 0) ? CycleCount - c : CycleCount - 1 - c;
    end
    return word_t'(k) * Delta;
  endfunction

  // Key word selected by a given half-round.
  function automatic key_sel_t stage_key(int unsigned stage, logic dec);
    word_t s;
    s = stage_sum(stage, dec);
    return stage_upd_first(stage, dec) ? s[1:0] : s[12:11];
  endfunction

endpackage

[hdl/xtea_block_cipher.sv]
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully unrolled XTEA pipeline with an APB key port and valid/stall channels.
// ----------------------------------------------------------------------------
// Each input transfer carries a 64-bit block as two 32-bit words and a
// request type (0 encipher, 1 decipher); each produces exactly one output
// transfer with the processed block, in order. The 128-bit key is held in
// four 32-bit registers at APB byte addresses 0x0, 0x4, 0x8 and 0xC, which
// reset to zero and must only be written while no block is in flight. The
// cipher is cut into 64 register stages, one per Feistel half-round, so the
// block takes one new transfer every clock cycle unless the output stalls. The
// whole pipeline advances together: while a finished result waits at the
// output and is stalled, the pipeline holds and the input is stalled as well;
// whenever the output slot is free or drained the pipeline moves and a new
// transfer is taken.
module xtea_block_cipher
  import xtea_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  // Input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [31:0]      block_first_i,
  input  logic [31:0]      block_second_i,

  // Output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      out_first_o,
  output logic [31:0]      out_second_o
);

  // --------------------------------------------------------------------------
  // Key registers. The register index is taken from the word address; the
  // address decode covers exactly the four key words.
  // --------------------------------------------------------------------------
  word_t    key_q [NumKeys];
  key_idx_e cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = key_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        KEY_A:   key_q[KEY_A] <= pwdata;
        KEY_B:   key_q[KEY_B] <= pwdata;
        KEY_C:   key_q[KEY_C] <= pwdata;
        KEY_D:   key_q[KEY_D] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      KEY_A:   prdata = key_q[KEY_A];
      KEY_B:   prdata = key_q[KEY_B];
      KEY_C:   prdata = key_q[KEY_C];
      KEY_D:   prdata = key_q[KEY_D];
      default: prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control. The last stage doubles as the output register, so the
  // pipeline may move whenever that register is empty or being drained.
  // --------------------------------------------------------------------------
  logic  adv;
  logic  valid_q [NumStages];
  logic  dec_q   [NumStages];
  word_t v0_q    [NumStages];
  word_t v1_q    [NumStages];

  assign adv        = !(valid_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // One half-round per stage. The round sum and the key word index are fixed
  // for each stage and request type, so only a two-way pick by the request
  // type is left in the datapath.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam logic     UpdFirstEnc = stage_upd_first(s, 1'b0);
    localparam logic     UpdFirstDec = stage_upd_first(s, 1'b1);
    localparam word_t    SumEnc      = stage_sum(s, 1'b0);
    localparam word_t    SumDec      = stage_sum(s, 1'b1);
    localparam key_sel_t KeyEnc      = stage_key(s, 1'b0);
    localparam key_sel_t KeyDec      = stage_key(s, 1'b1);

    logic  valid_in;
    logic  dec_in;
    word_t v0_in;
    word_t v1_in;
    logic  upd_first;
    word_t sum;
    word_t key;
    word_t src;
    word_t dst;
    word_t tweak;
    word_t res;
    word_t v0_d;
    word_t v1_d;

    if (s == 0) begin : g_head
      assign valid_in = in_valid_i;
      assign dec_in   = req_type_i;
      assign v0_in    = block_first_i;
      assign v1_in    = block_second_i;
    end else begin : g_body
      assign valid_in = valid_q[s-1];
      assign dec_in   = dec_q[s-1];
      assign v0_in    = v0_q[s-1];
      assign v1_in    = v1_q[s-1];
    end

    always_comb begin
      upd_first = dec_in ? UpdFirstDec : UpdFirstEnc;
      sum       = dec_in ? SumDec : SumEnc;
      key       = dec_in ? key_q[KeyDec] : key_q[KeyEnc];
      src       = upd_first ? v1_in : v0_in;
      dst       = upd_first ? v0_in : v1_in;
      tweak     = mix_word(src) ^ (sum + key);
      res       = dec_in ? (dst - tweak) : (dst + tweak);
      v0_d      = upd_first ? res : v0_in;
      v1_d      = upd_first ? v1_in : res;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv && valid_in) begin
        dec_q[s] <= dec_in;
        v0_q[s]  <= v0_d;
        v1_q[s]  <= v1_d;
      end
    end
  end

  assign out_valid_o  = valid_q[NumStages-1];
  assign out_first_o  = v0_q[NumStages-1];
  assign out_second_o = v1_q[NumStages-1];

endmodule

[dv/tb_xtea_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Drives blocks through the cipher pipeline under a range of keys and compares
// every output transfer with an in-order prediction of the XTEA result.
// ----------------------------------------------------------------------------
// The key is written over the APB port only while the pipeline is empty. It is
// then read back. Each block taken on the input channel is enciphered or
// deciphered by a behavioural model in this file. The result is queued and
// compared field by field with the next output transfer. Both channels idle
// and stall at random, with stretches of full rate in between. A watchdog ends
// the run if no transfer happens on either channel for too long.
module tb_xtea_block_cipher
  import xtea_pkg::*;
();

  // Request types carried on req_type_i.
  localparam logic OpEncipher = 1'b0;
  localparam logic OpDecipher = 1'b1;

  // Wait allowed for the pipeline to empty before a key is changed, and at the
  // end of the run.
  localparam int unsigned HoldOff = NumStages + 8;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The slowest correct pause is a full drain, then the hold-off, then eight
  // APB accesses, so this limit is ample.
  localparam int unsigned StuckLimit = 2000;

  typedef struct packed {
    word_t first;
    word_t second;
  } cipher_block_t;

  // All inputs start at known values, so nothing floats before reset.
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             psel           = 1'b0;
  logic             penable        = 1'b0;
  logic             pwrite         = 1'b0;
  logic [AddrW-1:0] paddr          = '0;
  logic [31:0]      pwdata         = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             req_type_i     = OpEncipher;
  logic [31:0]      block_first_i  = '0;
  logic [31:0]      block_second_i = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [31:0]      out_first_o;
  logic [31:0]      out_second_o;

  // Our own copy of the key registers, kept in step with every APB write.
  word_t         key_copy [NumKeys];
  // Blocks that the cipher should deliver, oldest first.
  cipher_block_t predicted_blocks [$];
  cipher_block_t oldest_block;
  int unsigned   mismatch_count;
  int unsigned   stuck_cycles;
  int unsigned   stall_cycles;
  // While set, neither side idles or stalls, so the pipeline runs at full rate.
  bit            steady_flow;

  xtea_block_cipher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .block_first_i  (block_first_i),
    .block_second_i (block_second_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_first_o    (out_first_o),
    .out_second_o   (out_second_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Non-linear part of one Feistel half-round.
  function automatic word_t round_mix(word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Full XTEA over CycleCount cycles. The half-round that updates the first
  // word takes its key from sum bits 1..0. The other half-round takes its key
  // from sum bits 12..11. Decipher starts at delta times the cycle count and
  // runs the same steps backwards. All arithmetic wraps at 32 bits.
  function automatic cipher_block_t xtea_transform(logic op, word_t first, word_t second);
    word_t v0;
    word_t v1;
    word_t total;
    v0 = first;
    v1 = second;
    if (op == OpEncipher) begin
      total = '0;
      for (int c = 0; c < CycleCount; c++) begin
        v0 += round_mix(v1) ^ (total + key_copy[total[1:0]]);
        total += Delta;
        v1 += round_mix(v0) ^ (total + key_copy[total[12:11]]);
      end
    end else begin
      total = Delta * word_t'(CycleCount);
      for (int c = 0; c < CycleCount; c++) begin
        v1 -= round_mix(v0) ^ (total + key_copy[total[12:11]]);
        total -= Delta;
        v0 -= round_mix(v1) ^ (total + key_copy[total[1:0]]);
      end
    end
    return '{first: v0, second: v1};
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offers one block after a random gap and returns at the clock edge at which
  // it is taken. Valid stays high on return. A following call with no gap only
  // replaces the payload, so valid never dips between back-to-back transfers.
  task automatic send_block(logic op, word_t first, word_t second);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= op;
    block_first_i  <= first;
    block_second_i <= second;
    do @(posedge clk_i); while (in_stall_o);
    predicted_blocks.push_back(xtea_transform(op, first, second));
  endtask

  // Drops valid and waits until every predicted block has been delivered.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (predicted_blocks.size() != 0) @(posedge clk_i);
  endtask

  // The receiver stalls for a random number of cycles before each result. It
  // then holds stall low until a transfer completes.
  always begin
    stall_cycles = steady_flow ? 0 : $urandom_range(0, 8);
    if (stall_cycles != 0) begin
      out_stall_i <= 1'b1;
      repeat (stall_cycles) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!out_valid_o);
  end

  // Each output transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_blocks.size() == 0) begin
        $error("Unexpected output transfer: out_first %h, out_second %h",
               out_first_o, out_second_o);
        mismatch_count++;
      end else begin
        oldest_block = predicted_blocks.pop_front();
        if (out_first_o !== oldest_block.first) begin
          $error("out_first: expected %h, got %h", oldest_block.first, out_first_o);
          mismatch_count++;
        end
        if (out_second_o !== oldest_block.second) begin
          $error("out_second: expected %h, got %h", oldest_block.second, out_second_o);
          mismatch_count++;
        end
      end
    end
  end

  // Abandons the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Key port
  // --------------------------------------------------------------------------

  // One APB access to a key register: a setup cycle, then an access cycle that
  // completes when pready is high, then the bus returns to idle. A write updates
  // the local copy of the key. A read checks prdata against that copy.
  task automatic key_access(logic is_write, key_idx_e idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (is_write) begin
      key_copy[idx] = value;
    end else if (prdata !== key_copy[idx]) begin
      $error("prdata: expected %h, got %h", key_copy[idx], prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads a new key once the pipeline has emptied, then reads all four words
  // back.
  task automatic load_key(word_t a, word_t b, word_t c, word_t d);
    word_t words [NumKeys];
    words = '{a, b, c, d};
    wait_for_results();
    repeat (HoldOff) @(posedge clk_i);
    for (int i = 0; i < NumKeys; i++) key_access(1'b1, key_idx_e'(i), words[i]);
    for (int i = 0; i < NumKeys; i++) key_access(1'b0, key_idx_e'(i), '0);
  endtask

  // Mostly uniform words, with a share of all-zero, all-one, single-bit-set and
  // single-bit-clear patterns.
  function automatic word_t pick_word();
    word_t one_bit;
    one_bit = word_t'(1) << $urandom_range(0, WordW - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return one_bit;
      3:       return ~one_bit;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic pick_op();
    return $urandom_range(0, 1) ? OpDecipher : OpEncipher;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The key registers come out of reset as zero. Check the read-back, then
  // cipher the extreme blocks under the all-zero key.
  task automatic test_reset_key();
    for (int i = 0; i < NumKeys; i++) key_access(1'b0, key_idx_e'(i), '0);
    send_block(OpEncipher, '0, '0);
    send_block(OpDecipher, '0, '0);
    send_block(OpEncipher, '1, '1);
    send_block(OpDecipher, '1, '1);
  endtask

  // The all-ones key, then four distinct words, so that selecting the wrong
  // word in either half-round shows up.
  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block(OpEncipher, '0, '1);
    send_block(OpDecipher, '1, '0);
    send_block(OpEncipher, 32'h8000_0000, 32'h0000_0001);
    send_block(OpDecipher, 32'h0000_0001, 32'h8000_0000);
    load_key(32'h0000_0001, 32'h0000_0100, 32'h0001_0000, 32'h8000_0000);
    send_block(OpEncipher, '0, '0);
    send_block(OpDecipher, '0, '0);
    send_block(OpEncipher, '1, '1);
    send_block(OpDecipher, '1, '1);
  endtask

  // Encipher a block, then decipher the predicted ciphertext, for two blocks.
  // Each decipher result must give the plaintext back.
  task automatic test_round_trip();
    cipher_block_t sealed;
    load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    for (int i = 0; i < 2; i++) begin
      sealed = xtea_transform(OpEncipher, 32'h4142_4344 + i, 32'h4546_4748);
      send_block(OpEncipher, 32'h4142_4344 + i, 32'h4546_4748);
      send_block(OpDecipher, sealed.first, sealed.second);
    end
  endtask

  // Several key settings, each followed by random traffic. The idling style
  // is picked anew every fifty blocks. At one point in the middle, the sender
  // holds off until the pipeline has emptied.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 4) begin
        load_key('0, '1, '0, '1);
      end else begin
        load_key(pick_word(), pick_word(), pick_word(), pick_word());
      end
      for (int n = 0; n < 300; n++) begin
        if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        if (phase == 2 && n == 150) wait_for_results();
        send_block(pick_op(), pick_word(), pick_word());
      end
    end
    steady_flow = 1'b0;
  endtask

  // Back-to-back blocks with the receiver always ready. This keeps every stage
  // of the pipeline occupied.
  task automatic test_full_rate();
    steady_flow = 1'b1;
    for (int n = 0; n < 100; n++) send_block(pick_op(), $urandom, $urandom);
    steady_flow = 1'b0;
  endtask

  // A short burst, a pause until every result is back, then another burst.
  task automatic test_pause_until_drained();
    for (int n = 0; n < 15; n++) send_block(pick_op(), $urandom, $urandom);
    wait_for_results();
    for (int n = 0; n < 15; n++) send_block(pick_op(), $urandom, $urandom);
  endtask

  initial begin
    mismatch_count = 0;
    stuck_cycles   = 0;
    steady_flow    = 1'b0;
    for (int i = 0; i < NumKeys; i++) key_copy[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_round_trip();
    test_random_traffic();
    test_full_rate();
    test_pause_until_drained();

    // Let the last results come out. Then wait out the hold-off, so that any
    // extra output transfer is caught.
    wait_for_results();
    repeat (HoldOff) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
